@@ src/mlm_pkg.sv @@
package mlm_pkg;

   localparam int MAX_WINDOW_DEF     = 32768;
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 30;

   localparam int SIG_W     = 40;
   localparam int SIG_FRAC  = 38;
   localparam int SQ_W      = 48;
   localparam int SUM_W     = 64;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;
   localparam int LOUD_W    = 16;

   localparam logic [15:0]        WIN_LEN_RESET = 16'd19200;
   localparam logic signed [15:0] FLOOR_RESET   = -16'sd10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRE_B0_B1      = 3'd0,
      CSR_PRE_B2_A1      = 3'd1,
      CSR_PRE_A2_RLB_B0  = 3'd2,
      CSR_RLB_B1_B2      = 3'd3,
      CSR_RLB_A1_A2      = 3'd4,
      CSR_WINDOW_LENGTH  = 3'd5,
      CSR_LOUDNESS_FLOOR = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] b0;
      logic signed [31:0] b1;
      logic signed [31:0] b2;
      logic signed [31:0] a1;
      logic signed [31:0] a2;
   } biquad_type;

   typedef struct packed {
      logic start;
      logic stereo;
      logic set_peak;
   } merge_cmd_type;

endpackage

@@ src/mlm_req_if.sv @@
interface mlm_req_if #(
   parameter int SAMPLE_BITS = mlm_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;
   logic                          two_channels;
   logic                          block_end;
   logic                          clear_peak;

   modport source (
      output valid, left_sample, right_sample, two_channels, block_end, clear_peak,
      input  ready
   );
   modport sink (
      input  valid, left_sample, right_sample, two_channels, block_end, clear_peak,
      output ready
   );
endinterface

@@ src/mlm_rsp_if.sv @@
interface mlm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [mlm_pkg::LOUD_W-1:0] momentary_loudness;
   logic signed [mlm_pkg::LOUD_W-1:0] peak_loudness;

   modport source (
      output valid, momentary_loudness, peak_loudness,
      input  ready
   );
   modport sink (
      input  valid, momentary_loudness, peak_loudness,
      output ready
   );
endinterface

@@ src/mlm_lane.sv @@
module mlm_lane #(
   parameter int MAX_WINDOW     = mlm_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS    = mlm_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = mlm_pkg::COEF_FRAC_BITS_DEF,
   localparam int LEN_W         = $clog2(MAX_WINDOW + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          restart,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  mlm_pkg::biquad_type           pre,
   input  mlm_pkg::biquad_type           rlb,
   input  logic [LEN_W-1:0]              win_len,
   output logic                          done,
   output logic [mlm_pkg::SUM_W-1:0]     win_sum,
   output logic [LEN_W-1:0]              fill
);

   localparam int SIG_W    = mlm_pkg::SIG_W;
   localparam int SQ_W     = mlm_pkg::SQ_W;
   localparam int SUM_W    = mlm_pkg::SUM_W;
   localparam int PW       = $clog2(MAX_WINDOW);
   localparam int IN_SHIFT = mlm_pkg::SIG_FRAC - SAMPLE_BITS + 1;
   localparam int ACC_W    = 80;
   localparam int PROD_W   = 54;
   localparam int STEP_W   = 5;

   localparam logic [STEP_W-1:0] S_PRE_END = 5'd9;
   localparam logic [STEP_W-1:0] S_Y0      = 5'd11;
   localparam logic [STEP_W-1:0] S_RLB_BEG = 5'd12;
   localparam logic [STEP_W-1:0] S_RLB_END = 5'd21;
   localparam logic [STEP_W-1:0] S_Z0      = 5'd23;
   localparam logic [STEP_W-1:0] S_SQ_HH   = 5'd24;
   localparam logic [STEP_W-1:0] S_SQ_HL   = 5'd25;
   localparam logic [STEP_W-1:0] S_SQ_LL   = 5'd26;
   localparam logic [STEP_W-1:0] S_PUSH    = 5'd28;
   localparam logic [STEP_W-1:0] S_DONE    = 5'd29;

   localparam logic signed [ACC_W-1:0] SIG_HI =
      {{(ACC_W-SIG_W+1){1'b0}}, {(SIG_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SIG_LO =
      {{(ACC_W-SIG_W+1){1'b1}}, {(SIG_W-1){1'b0}}};

   typedef enum logic [1:0] {SH_0, SH_20, SH_21, SH_40} shift_type;

   logic                      busy_ff;
   logic [STEP_W-1:0]         step_ff;
   logic signed [SIG_W-1:0]   x0_ff, y0_ff;
   logic signed [SIG_W-1:0]   pre_x1_ff, pre_x2_ff, pre_y1_ff, pre_y2_ff;
   logic signed [SIG_W-1:0]   rlb_x1_ff, rlb_x2_ff, rlb_y1_ff, rlb_y2_ff;
   logic [SIG_W-1:0]          mag_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   shift_type                 sh_ff;
   logic                      prod_vld_ff;
   logic [SQ_W-1:0]           mem_ff [MAX_WINDOW];
   logic [SQ_W-1:0]           rd_ff;
   logic [PW-1:0]             wp_ff;
   logic                      full_ff;
   logic [SUM_W-1:0]          sum_ff;

   logic                      issue, stage_rlb;
   logic [STEP_W-1:0]         idx;
   logic [2:0]                k;
   mlm_pkg::biquad_type       cset;
   logic signed [SIG_W-1:0]   v;
   logic signed [32:0]        a_op;
   logic signed [20:0]        b_op;
   shift_type                 sh;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]   prod_ext, prod_sh;
   logic signed [ACC_W-1:0]   acc_shr;
   logic signed [SIG_W-1:0]   y_sat;
   logic [49:0]               sq_wide;
   logic [SQ_W-1:0]           sq;
   logic [LEN_W-1:0]          wp_inc;
   logic                      push_en;

   // operand select per step
   always_comb begin
      issue     = 1'b0;
      idx       = '0;
      stage_rlb = (step_ff >= S_RLB_BEG);
      if (busy_ff && step_ff <= S_PRE_END) begin
         issue = 1'b1;
         idx   = step_ff;
      end else if (busy_ff && step_ff >= S_RLB_BEG && step_ff <= S_RLB_END) begin
         issue = 1'b1;
         idx   = step_ff - S_RLB_BEG;
      end
      k    = idx[3:1];
      cset = stage_rlb ? rlb : pre;
      case (k)
         3'd0: begin
            v    = stage_rlb ? y0_ff : x0_ff;
            a_op = 33'($signed(cset.b0));
         end
         3'd1: begin
            v    = stage_rlb ? rlb_x1_ff : pre_x1_ff;
            a_op = 33'($signed(cset.b1));
         end
         3'd2: begin
            v    = stage_rlb ? rlb_x2_ff : pre_x2_ff;
            a_op = 33'($signed(cset.b2));
         end
         3'd3: begin
            v    = stage_rlb ? rlb_y1_ff : pre_y1_ff;
            a_op = -33'($signed(cset.a1));
         end
         3'd4: begin
            v    = stage_rlb ? rlb_y2_ff : pre_y2_ff;
            a_op = -33'($signed(cset.a2));
         end
         default: begin
            v    = '0;
            a_op = '0;
         end
      endcase
      if (!idx[0]) begin
         b_op = {v[SIG_W-1], v[SIG_W-1:20]};
         sh   = SH_20;
      end else begin
         b_op = {1'b0, v[19:0]};
         sh   = SH_0;
      end
      if (busy_ff && step_ff == S_SQ_HH) begin
         issue = 1'b1;
         a_op  = {13'd0, mag_ff[39:20]};
         b_op  = {1'b0, mag_ff[39:20]};
         sh    = SH_40;
      end else if (busy_ff && step_ff == S_SQ_HL) begin
         issue = 1'b1;
         a_op  = {13'd0, mag_ff[39:20]};
         b_op  = {1'b0, mag_ff[19:0]};
         sh    = SH_21;
      end else if (busy_ff && step_ff == S_SQ_LL) begin
         issue = 1'b1;
         a_op  = {13'd0, mag_ff[19:0]};
         b_op  = {1'b0, mag_ff[19:0]};
         sh    = SH_0;
      end
   end

   assign prod_in  = a_op * b_op;
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      case (sh_ff)
         SH_20:   prod_sh = prod_ext <<< 20;
         SH_21:   prod_sh = prod_ext <<< 21;
         SH_40:   prod_sh = prod_ext <<< 40;
         default: prod_sh = prod_ext;
      endcase
   end

   // filter output: floor shift, saturate to signal width
   assign acc_shr = acc_ff >>> COEF_FRAC_BITS;
   always_comb begin
      if (acc_shr > SIG_HI)      y_sat = SIG_HI[SIG_W-1:0];
      else if (acc_shr < SIG_LO) y_sat = SIG_LO[SIG_W-1:0];
      else                       y_sat = acc_shr[SIG_W-1:0];
   end

   assign sq_wide = acc_ff[79:30];
   assign sq      = (|sq_wide[49:48]) ? '1 : sq_wide[SQ_W-1:0];
   assign wp_inc  = LEN_W'(wp_ff) + LEN_W'(1);
   assign push_en = busy_ff && step_ff == S_PUSH && win_len != '0;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sh_ff   <= sh;
      if (start) begin
         x0_ff <= SIG_W'(sample) <<< IN_SHIFT;
      end
      if (busy_ff && step_ff == S_Y0) begin
         y0_ff <= y_sat;
      end
      if (busy_ff && step_ff == S_Z0) begin
         mag_ff <= y_sat[SIG_W-1] ? SIG_W'(-y_sat) : SIG_W'(y_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         step_ff     <= '0;
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
         pre_x1_ff   <= '0;
         pre_x2_ff   <= '0;
         pre_y1_ff   <= '0;
         pre_y2_ff   <= '0;
         rlb_x1_ff   <= '0;
         rlb_x2_ff   <= '0;
         rlb_y1_ff   <= '0;
         rlb_y2_ff   <= '0;
         wp_ff       <= '0;
         full_ff     <= 1'b0;
         sum_ff      <= '0;
      end else begin
         prod_vld_ff <= issue;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == S_DONE) begin
               busy_ff <= 1'b0;
            end
         end
         if (start || (busy_ff && (step_ff == S_Y0 || step_ff == S_Z0))) begin
            acc_ff <= '0;
         end else if (prod_vld_ff) begin
            acc_ff <= acc_ff + prod_sh;
         end
         if (busy_ff && step_ff == S_Y0) begin
            pre_x2_ff <= pre_x1_ff;
            pre_x1_ff <= x0_ff;
            pre_y2_ff <= pre_y1_ff;
            pre_y1_ff <= y_sat;
         end
         if (busy_ff && step_ff == S_Z0) begin
            rlb_x2_ff <= rlb_x1_ff;
            rlb_x1_ff <= y0_ff;
            rlb_y2_ff <= rlb_y1_ff;
            rlb_y1_ff <= y_sat;
         end
         if (restart) begin
            wp_ff   <= '0;
            full_ff <= 1'b0;
            sum_ff  <= '0;
         end else if (push_en) begin
            sum_ff <= sum_ff - (full_ff ? SUM_W'(rd_ff) : '0) + SUM_W'(sq);
            if (wp_inc >= win_len) begin
               wp_ff   <= '0;
               full_ff <= 1'b1;
            end else begin
               wp_ff <= PW'(wp_inc);
            end
         end
      end
   end

   // window store
   always_ff @(posedge clock) begin
      if (busy_ff && step_ff == S_SQ_HH) begin
         rd_ff <= mem_ff[wp_ff];
      end
      if (push_en) begin
         mem_ff[wp_ff] <= sq;
      end
   end

   assign done    = busy_ff && step_ff == S_DONE;
   assign win_sum = sum_ff;
   assign fill    = full_ff ? win_len : LEN_W'(wp_ff);

endmodule

@@ src/mlm_merge.sv @@
module mlm_merge #(
   parameter int MAX_WINDOW = mlm_pkg::MAX_WINDOW_DEF,
   localparam int LEN_W     = $clog2(MAX_WINDOW + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mlm_pkg::merge_cmd_type        cmd,
   input  logic [mlm_pkg::SUM_W-1:0]     sum_l,
   input  logic [mlm_pkg::SUM_W-1:0]     sum_r,
   input  logic [LEN_W-1:0]              fill_l,
   input  logic [LEN_W-1:0]              fill_r,
   input  logic signed [mlm_pkg::LOUD_W-1:0] floor_raw,
   mlm_rsp_if.source                     rsp,
   output logic                          done
);

   localparam int SUM_W  = mlm_pkg::SUM_W;
   localparam int SQ_W   = mlm_pkg::SQ_W;
   localparam int LOUD_W = mlm_pkg::LOUD_W;
   localparam int TOT_W  = SQ_W + 1;

   localparam logic signed [25:0] K_LOG = 26'sd19728302;
   localparam logic signed [57:0] C_OFF = 58'sd75976253479322;
   localparam logic signed [17:0] TOP_LOUD = 18'sd2000;
   localparam logic signed [LOUD_W-1:0] FLOOR_MIN = -16'sd20000;

   typedef enum logic [6:0] {
      M_IDLE = 7'b0000001,
      M_DIV  = 7'b0000010,
      M_NORM = 7'b0000100,
      M_LOG  = 7'b0001000,
      M_MUL  = 7'b0010000,
      M_FIN  = 7'b0100000,
      M_OUT  = 7'b1000000
   } merge_state_type;

   merge_state_type           state_ff;
   logic                      stereo_ff, div_ch_ff, zero_ff;
   logic [5:0]                cnt_ff;
   logic [SUM_W-1:0]          quo_ff;
   logic [LEN_W-1:0]          rem_ff, dvs_ff;
   logic [SQ_W-1:0]           ml_ff;
   logic [TOT_W-1:0]          x_ff;
   logic [5:0]                n_ff;
   logic [30:0]               m_ff;
   logic [23:0]               frac_ff;
   logic signed [56:0]        lp_ff;
   logic signed [LOUD_W-1:0]  cur_ff, peak_ff;
   logic                      vld_ff;
   logic signed [LOUD_W-1:0]  out_m_ff, out_p_ff;

   logic [LEN_W:0]            trial;
   logic                      qbit;
   logic [SQ_W-1:0]           mean_last;
   logic [61:0]               msq;
   logic [31:0]               mt;
   logic signed [30:0]        l2;
   logic signed [57:0]        diff;
   logic signed [17:0]        h_w;
   logic signed [LOUD_W-1:0]  fl, h_fin;
   logic                      load;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign qbit  = trial >= {1'b0, dvs_ff};

   // mean of the current channel is taken after its last quotient bit
   assign mean_last = (dvs_ff == '0) ? '0 : {quo_ff[SQ_W-2:0], qbit};

   assign msq  = m_ff * m_ff;
   assign mt   = msq[61:30];
   assign l2   = {7'($signed({1'b0, n_ff}) - 7'sd46), frac_ff};
   assign diff = 58'(lp_ff) - C_OFF;
   assign h_w  = diff[57:40];

   always_comb begin
      if (floor_raw > 16'sd0)          fl = '0;
      else if (floor_raw < FLOOR_MIN)  fl = FLOOR_MIN;
      else                             fl = floor_raw;
      if (zero_ff)                     h_fin = fl;
      else if (h_w > TOP_LOUD)         h_fin = LOUD_W'(TOP_LOUD);
      else if (h_w < 18'(fl))          h_fin = fl;
      else                             h_fin = h_w[LOUD_W-1:0];
   end

   assign load = state_ff == M_OUT && (!vld_ff || rsp.ready);

   always_ff @(posedge clock) begin
      case (state_ff)
         M_IDLE: begin
            if (cmd.start) begin
               quo_ff <= sum_l;
               rem_ff <= '0;
               dvs_ff <= fill_l;
            end
         end
         M_DIV: begin
            quo_ff <= {quo_ff[SUM_W-2:0], qbit};
            rem_ff <= qbit ? LEN_W'(trial - {1'b0, dvs_ff}) : trial[LEN_W-1:0];
            if (cnt_ff == 6'd63) begin
               quo_ff <= sum_r;
               rem_ff <= '0;
               dvs_ff <= fill_r;
            end
         end
         M_MUL: lp_ff <= l2 * K_LOG;
         default: ;
      endcase
      if (load) begin
         out_m_ff <= cur_ff;
         out_p_ff <= peak_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= M_IDLE;
         stereo_ff <= 1'b0;
         div_ch_ff <= 1'b0;
         zero_ff   <= 1'b0;
         cnt_ff    <= '0;
         ml_ff     <= '0;
         x_ff      <= '0;
         n_ff      <= '0;
         m_ff      <= '0;
         frac_ff   <= '0;
         cur_ff    <= mlm_pkg::FLOOR_RESET;
         peak_ff   <= mlm_pkg::FLOOR_RESET;
         vld_ff    <= 1'b0;
      end else begin
         if (cmd.set_peak) begin
            peak_ff <= cur_ff;
         end
         if (rsp.ready) begin
            vld_ff <= 1'b0;
         end
         case (state_ff)
            M_IDLE: begin
               if (cmd.start) begin
                  stereo_ff <= cmd.stereo;
                  div_ch_ff <= 1'b0;
                  cnt_ff    <= '0;
                  state_ff  <= M_DIV;
               end
            end
            M_DIV: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  ml_ff <= mean_last;
                  if (stereo_ff && !div_ch_ff) begin
                     div_ch_ff <= 1'b1;
                  end else begin
                     x_ff     <= TOT_W'(stereo_ff ? ml_ff : mean_last) + TOT_W'(mean_last);
                     zero_ff  <= (TOT_W'(stereo_ff ? ml_ff : mean_last)
                                  + TOT_W'(mean_last)) == '0;
                     n_ff     <= 6'(TOT_W - 1);
                     state_ff <= M_NORM;
                  end
               end
            end
            M_NORM: begin
               if (zero_ff) begin
                  state_ff <= M_FIN;
               end else if (x_ff[TOT_W-1]) begin
                  m_ff     <= x_ff[TOT_W-1:TOT_W-31];
                  frac_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= M_LOG;
               end else begin
                  x_ff <= {x_ff[TOT_W-2:0], 1'b0};
                  n_ff <= n_ff - 6'd1;
               end
            end
            M_LOG: begin
               m_ff    <= mt[31] ? mt[31:1] : mt[30:0];
               frac_ff <= {frac_ff[22:0], mt[31]};
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd23) begin
                  state_ff <= M_MUL;
               end
            end
            M_MUL: state_ff <= M_FIN;
            M_FIN: begin
               cur_ff <= h_fin;
               if (h_fin > peak_ff) begin
                  peak_ff <= h_fin;
               end
               state_ff <= M_OUT;
            end
            M_OUT: begin
               if (load) begin
                  vld_ff   <= 1'b1;
                  state_ff <= M_IDLE;
               end
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done                   = load;
   assign rsp.valid              = vld_ff;
   assign rsp.momentary_loudness = out_m_ff;
   assign rsp.peak_loudness      = out_p_ff;

endmodule

@@ src/momentary_loudness_meter_top.sv @@
// momentary loudness meter, k-weighted 400 ms style sliding window
// req_chan carries one stereo or mono frame per word (valid/ready). each
// channel lane runs its two biquads and the square on one shared 33x21
// multiplier, then updates its window memory; the next frame is taken only
// once the lanes (and the merge unit, on a block end) have finished.
// a frame with block_end also runs the merge unit: one 64-step restoring
// divide per active channel, a leading-one search of up to 49 steps, 24
// squaring steps for log2 and a scale step, before the loudness word is loaded
// into the rsp_chan output register.
// frames without block_end give no word.
// csr_wr_en with csr_index/csr_wdata writes one register per cycle; the user must
// write only while idle (not enforced); writing the window length empties both windows.
// reset (synchronous) clears filter history, windows and handshake state and
// sets current and peak loudness to -100.00 LU. the window memories need no
// clearing pass: entries are read only after being written since the last
// window restart.
// when the receiver stalls the result word holds in the output register; the
// next frame is still taken, and a later block end waits for the register.
module momentary_loudness_meter_top #(
   parameter int MAX_WINDOW     = mlm_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS    = mlm_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = mlm_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   mlm_req_if.sink                           req_chan,
   mlm_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [mlm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mlm_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int LEN_W = $clog2(MAX_WINDOW + 1);

   typedef enum logic [2:0] {
      T_IDLE  = 3'b001,
      T_LANE  = 3'b010,
      T_MERGE = 3'b100
   } top_state_type;

   top_state_type              state_ff;
   logic [1:0]                 pend_ff;
   logic                       stereo_ff, end_ff;
   logic [mlm_pkg::CSR_W-1:0]  reg_ff [5];
   logic [15:0]                win_len_ff;
   logic signed [15:0]         floor_ff;

   logic                       accept, restart;
   logic [1:0]                 lane_done, pend_left;
   logic [LEN_W-1:0]           eff_len;
   mlm_pkg::biquad_type        pre, rlb;
   mlm_pkg::merge_cmd_type     cmd;
   logic [mlm_pkg::SUM_W-1:0]  sum_l, sum_r;
   logic [LEN_W-1:0]           fill_l, fill_r;
   logic                       merge_done;

   assign req_chan.ready = (state_ff == T_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign restart        = csr_wr_en &&
                           csr_index == mlm_pkg::CSR_WINDOW_LENGTH;
   assign eff_len        = (32'(win_len_ff) > MAX_WINDOW) ?
                           LEN_W'(MAX_WINDOW) : LEN_W'(win_len_ff);

   assign pre.b0 = reg_ff[0][63:32];
   assign pre.b1 = reg_ff[0][31:0];
   assign pre.b2 = reg_ff[1][63:32];
   assign pre.a1 = reg_ff[1][31:0];
   assign pre.a2 = reg_ff[2][63:32];
   assign rlb.b0 = reg_ff[2][31:0];
   assign rlb.b1 = reg_ff[3][63:32];
   assign rlb.b2 = reg_ff[3][31:0];
   assign rlb.a1 = reg_ff[4][63:32];
   assign rlb.a2 = reg_ff[4][31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            reg_ff[i] <= '0;
         end
         win_len_ff <= mlm_pkg::WIN_LEN_RESET;
         floor_ff   <= mlm_pkg::FLOOR_RESET;
      end else if (csr_wr_en) begin
         case (mlm_pkg::csr_index_type'(csr_index))
            mlm_pkg::CSR_PRE_B0_B1:      reg_ff[0] <= csr_wdata;
            mlm_pkg::CSR_PRE_B2_A1:      reg_ff[1] <= csr_wdata;
            mlm_pkg::CSR_PRE_A2_RLB_B0:  reg_ff[2] <= csr_wdata;
            mlm_pkg::CSR_RLB_B1_B2:      reg_ff[3] <= csr_wdata;
            mlm_pkg::CSR_RLB_A1_A2:      reg_ff[4] <= csr_wdata;
            mlm_pkg::CSR_WINDOW_LENGTH:  win_len_ff <= csr_wdata[15:0];
            mlm_pkg::CSR_LOUDNESS_FLOOR: floor_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign pend_left    = pend_ff & ~lane_done;
   assign cmd.start    = (state_ff == T_LANE) && pend_left == 2'b00 && end_ff;
   assign cmd.stereo   = stereo_ff;
   assign cmd.set_peak = accept && req_chan.clear_peak;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= T_IDLE;
         pend_ff   <= '0;
         stereo_ff <= 1'b0;
         end_ff    <= 1'b0;
      end else begin
         case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  stereo_ff <= req_chan.two_channels;
                  end_ff    <= req_chan.block_end;
                  pend_ff   <= {req_chan.two_channels, 1'b1};
                  state_ff  <= T_LANE;
               end
            end
            T_LANE: begin
               pend_ff <= pend_left;
               if (pend_left == 2'b00) begin
                  state_ff <= end_ff ? T_MERGE : T_IDLE;
               end
            end
            T_MERGE: begin
               if (merge_done) begin
                  state_ff <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   mlm_lane #(
      .MAX_WINDOW     (MAX_WINDOW),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_l (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .restart (restart),
      .sample  (req_chan.left_sample),
      .pre     (pre),
      .rlb     (rlb),
      .win_len (eff_len),
      .done    (lane_done[0]),
      .win_sum (sum_l),
      .fill    (fill_l)
   );

   mlm_lane #(
      .MAX_WINDOW     (MAX_WINDOW),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_r (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && req_chan.two_channels),
      .restart (restart),
      .sample  (req_chan.right_sample),
      .pre     (pre),
      .rlb     (rlb),
      .win_len (eff_len),
      .done    (lane_done[1]),
      .win_sum (sum_r),
      .fill    (fill_r)
   );

   mlm_merge #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sum_l     (sum_l),
      .sum_r     (sum_r),
      .fill_l    (fill_l),
      .fill_r    (fill_r),
      .floor_raw (floor_ff),
      .rsp       (rsp_chan),
      .done      (merge_done)
   );

endmodule

@@ tb/momentary_loudness_meter_top_tb.sv @@
module momentary_loudness_meter_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN_MAX    = mlm_pkg::MAX_WINDOW_DEF;
   localparam int SETTLE_CYC = 300;
   localparam int STALL_LIM  = 5000;

   typedef struct {
      logic signed [15:0] momentary;
      logic signed [15:0] peak;
   } loud_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [mlm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mlm_pkg::CSR_W-1:0] csr_wdata = '0;

   mlm_req_if req_chan ();
   mlm_rsp_if rsp_chan ();

   momentary_loudness_meter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // shadow registers and meter state
   bit [63:0]         coef_reg [5];
   bit [15:0]         win_len_reg;
   bit [15:0]         floor_reg;
   longint signed     filt_hist [2][8];
   bit [47:0]         square_store [2][WIN_MAX];
   bit [63:0]         win_sum [2];
   int unsigned       win_pos [2];
   bit                win_full [2];
   int signed         cur_loud;
   int signed         peak_loud;

   loud_word_type loud_expect_q [$];
   int  mismatch_cnt = 0;
   int  frame_cnt = 0;
   int  word_cnt = 0;
   bit  idle_on = 1'b0;
   int  stall_left = 0;
   int  quiet_cycles = 0;

   function automatic longint signed coef_half(int r, bit hi);
      logic signed [31:0] h;
      h = hi ? coef_reg[r][63:32] : coef_reg[r][31:0];
      return h;
   endfunction

   function automatic int signed floor_now();
      int signed f;
      f = int'($signed(floor_reg));
      if (f < -20000) f = -20000;
      if (f > 0) f = 0;
      return f;
   endfunction

   function automatic int unsigned len_now();
      return (win_len_reg > WIN_MAX) ? WIN_MAX : win_len_reg;
   endfunction

   function automatic longint signed biquad_sum(longint signed c[5], longint signed v[5]);
      logic signed [79:0] acc;
      acc = '0;
      for (int k = 0; k < 5; k++) acc = acc + c[k] * v[k];
      acc = acc >>> mlm_pkg::COEF_FRAC_BITS_DEF;
      if (acc > 80'sd549755813887) acc = 80'sd549755813887;
      if (acc < -80'sd549755813888) acc = -80'sd549755813888;
      return longint'(acc[63:0]);
   endfunction

   function automatic longint signed k_weight(int ch, longint signed x0);
      longint signed c[5];
      longint signed v[5];
      longint signed y0, z0;
      c[0] = coef_half(0, 1); c[1] = coef_half(0, 0); c[2] = coef_half(1, 1);
      c[3] = -coef_half(1, 0); c[4] = -coef_half(2, 1);
      v[0] = x0; v[1] = filt_hist[ch][0]; v[2] = filt_hist[ch][1];
      v[3] = filt_hist[ch][2]; v[4] = filt_hist[ch][3];
      y0 = biquad_sum(c, v);
      filt_hist[ch][1] = filt_hist[ch][0]; filt_hist[ch][0] = x0;
      filt_hist[ch][3] = filt_hist[ch][2]; filt_hist[ch][2] = y0;
      c[0] = coef_half(2, 0); c[1] = coef_half(3, 1); c[2] = coef_half(3, 0);
      c[3] = -coef_half(4, 1); c[4] = -coef_half(4, 0);
      v[0] = y0; v[1] = filt_hist[ch][4]; v[2] = filt_hist[ch][5];
      v[3] = filt_hist[ch][6]; v[4] = filt_hist[ch][7];
      z0 = biquad_sum(c, v);
      filt_hist[ch][5] = filt_hist[ch][4]; filt_hist[ch][4] = y0;
      filt_hist[ch][7] = filt_hist[ch][6]; filt_hist[ch][6] = z0;
      return z0;
   endfunction

   function automatic bit [47:0] square_q46(longint signed w);
      logic signed [79:0] ws, p;
      ws = w;
      p = ws * ws;
      p = p >>> 30;
      if (p > 80'sd281474976710655) return 48'hFFFF_FFFF_FFFF;
      return p[47:0];
   endfunction

   function automatic void window_push(int ch, bit [47:0] sq);
      int unsigned len, p;
      len = len_now();
      p = win_pos[ch];
      if (len == 0) return;
      if (p >= len) p = 0;
      if (win_full[ch]) win_sum[ch] -= square_store[ch][p];
      square_store[ch][p] = sq;
      win_sum[ch] += sq;
      p++;
      if (p >= len) begin
         p = 0;
         win_full[ch] = 1'b1;
      end
      win_pos[ch] = p;
   endfunction

   function automatic bit [63:0] window_mean(int ch);
      bit [63:0] n;
      n = win_full[ch] ? len_now() : win_pos[ch];
      return (n == 0) ? 64'd0 : win_sum[ch] / n;
   endfunction

   function automatic int signed loudness_of(bit [63:0] total);
      int n;
      bit [63:0] m, frac;
      longint signed l2, hv;
      if (total == 0) return floor_now();
      n = 63;
      frac = '0;
      while (!total[n]) n--;
      m = (n >= 30) ? total >> (n - 30) : total << (30 - n);
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac[i] = 1'b1;
         end
      end
      l2 = longint'(n - 46) * (64'sd1 <<< 24) + longint'(frac);
      hv = (l2 * 64'sd19728302 - 64'sd75976253479322) >>> 40;
      if (hv > 2000) hv = 2000;
      if (hv < floor_now()) hv = floor_now();
      return int'(hv);
   endfunction

   function automatic void meter_reset();
      foreach (coef_reg[i]) coef_reg[i] = '0;
      win_len_reg = mlm_pkg::WIN_LEN_RESET;
      floor_reg = mlm_pkg::FLOOR_RESET;
      foreach (filt_hist[c, k]) filt_hist[c][k] = 0;
      for (int c = 0; c < 2; c++) begin
         win_sum[c] = '0;
         win_pos[c] = 0;
         win_full[c] = 1'b0;
      end
      cur_loud = floor_now();
      peak_loud = cur_loud;
   endfunction

   function automatic void meter_frame(logic signed [23:0] l, logic signed [23:0] r,
                                       bit st, bit be, bit cp);
      bit [63:0] ml, mr;
      loud_word_type w;
      if (cp) peak_loud = cur_loud;
      window_push(0, square_q46(k_weight(0, longint'(l) <<< 15)));
      if (st) window_push(1, square_q46(k_weight(1, longint'(r) <<< 15)));
      if (!be) return;
      ml = window_mean(0);
      mr = st ? window_mean(1) : ml;
      cur_loud = loudness_of(ml + mr);
      if (cur_loud > peak_loud) peak_loud = cur_loud;
      w.momentary = cur_loud[15:0];
      w.peak = peak_loud[15:0];
      loud_expect_q.push_back(w);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_cnt++;
   endtask

   // result checker and watchdog
   always @(posedge clock) begin
      loud_word_type w;
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIM) begin
            $display("CHECK FAILED");
            $finish;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            word_cnt++;
            if (loud_expect_q.size() == 0) begin
               report_mismatch("unexpected word", rsp_chan.momentary_loudness, 0);
            end else begin
               w = loud_expect_q.pop_front();
               if (rsp_chan.momentary_loudness !== w.momentary)
                  report_mismatch("momentary", rsp_chan.momentary_loudness, w.momentary);
               if (rsp_chan.peak_loudness !== w.peak)
                  report_mismatch("peak", rsp_chan.peak_loudness, w.peak);
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready = 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_chan.ready = 1'b0;
         stall_left = $urandom_range(1, 16) - 1;
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r,
                             bit st, bit be, bit cp);
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.left_sample = l;
      req_chan.right_sample = r;
      req_chan.two_channels = st;
      req_chan.block_end = be;
      req_chan.clear_peak = cp;
      do @(posedge clock); while (!req_chan.ready);
      meter_frame(l, r, st, be, cp);
      frame_cnt++;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 16) - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (loud_expect_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_write(mlm_pkg::csr_index_type idx, bit [63:0] d);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = d;
      if (idx == mlm_pkg::CSR_WINDOW_LENGTH) begin
         win_len_reg = d[15:0];
         for (int c = 0; c < 2; c++) begin
            win_sum[c] = '0;
            win_pos[c] = 0;
            win_full[c] = 1'b0;
         end
      end else if (idx == mlm_pkg::CSR_LOUDNESS_FLOOR) begin
         floor_reg = d[15:0];
      end else begin
         coef_reg[idx] = d;
      end
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic bit [31:0] q30(real r);
      return 32'(longint'($floor(r * 1073741824.0)));
   endfunction

   task automatic load_k_weighting();
      csr_write(mlm_pkg::CSR_PRE_B0_B1, {q30(1.53512485958697), q30(-2.69169618940638)});
      csr_write(mlm_pkg::CSR_PRE_B2_A1, {q30(1.19839281085285), q30(-1.69065929318241)});
      csr_write(mlm_pkg::CSR_PRE_A2_RLB_B0, {q30(0.73248077421585), q30(1.0)});
      csr_write(mlm_pkg::CSR_RLB_B1_B2, {q30(-2.0), q30(1.0)});
      csr_write(mlm_pkg::CSR_RLB_A1_A2, {q30(-1.99004745483398), q30(0.99007225036621)});
   endtask

   task automatic random_frame(int be_odds);
      logic signed [23:0] l, r;
      l = $signed(24'($urandom)) >>> $urandom_range(0, 23);
      r = $signed(24'($urandom)) >>> $urandom_range(0, 23);
      send_frame(l, r, $urandom_range(0, 3) != 0, $urandom_range(0, be_odds) == 0,
                 $urandom_range(0, 9) == 0);
   endtask

   task automatic test_reset_defaults();
      send_frame(24'sh7FFFFF, 24'sh800000, 1, 1, 0);
      send_frame(24'sh123456, 24'sh654321, 0, 0, 1);
      send_frame(24'sh000000, 24'sh000000, 1, 1, 1);
      drain();
   endtask

   task automatic test_directed_extremes();
      load_k_weighting();
      csr_write(mlm_pkg::CSR_WINDOW_LENGTH, 64'd8);
      send_frame(24'sh000000, 24'sh000000, 1, 1, 0);
      for (int i = 0; i < 6; i++) send_frame(24'sh7FFFFF, 24'sh800000, 1, 0, 0);
      send_frame(24'sh800000, 24'sh7FFFFF, 1, 1, 0);
      for (int i = 0; i < 4; i++) send_frame(24'sh800000, 24'sh7FFFFF, 0, 0, 0);
      send_frame(24'sh7FFFFF, 24'sh000001, 0, 1, 0);
      send_frame(24'sh000001, 24'shFFFFFF, 1, 1, 1);
      send_frame(24'sh000010, 24'sh000000, 1, 1, 0);
      send_frame(24'sh000000, 24'sh7FFFFF, 0, 1, 1);
      for (int i = 0; i < 8; i++) send_frame(24'sh000000, 24'sh000000, 1, 0, 0);
      send_frame(24'sh000000, 24'sh000000, 1, 1, 0);
      drain();
   endtask

   task automatic test_window_lengths();
      bit [15:0] lens [7] = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd32768, 16'd40000, 16'd37};
      foreach (lens[i]) begin
         csr_write(mlm_pkg::CSR_WINDOW_LENGTH, {48'($urandom), lens[i]});
         repeat (60) random_frame(5);
         drain();
      end
   endtask

   task automatic test_floor_settings();
      bit [15:0] floors [5] = '{16'h0000, 16'h8000, 16'h7FFF, -16'sd20000, -16'sd1};
      csr_write(mlm_pkg::CSR_WINDOW_LENGTH, 64'd16);
      foreach (floors[i]) begin
         csr_write(mlm_pkg::CSR_LOUDNESS_FLOOR, {48'($urandom), floors[i]});
         send_frame(24'sh000000, 24'sh000000, 1, 1, 1);
         repeat (40) random_frame(4);
         drain();
      end
      csr_write(mlm_pkg::CSR_LOUDNESS_FLOOR, 64'($urandom_range(0, 20000)) * -1);
      drain();
   endtask

   task automatic test_random_coefs();
      for (int s = 0; s < 4; s++) begin
         for (int r = 0; r < 5; r++)
            if (s < 2)
               csr_write(mlm_pkg::csr_index_type'(r), {$urandom, $urandom});
            else
               csr_write(mlm_pkg::csr_index_type'(r), {32'($signed($urandom) >>> 2),
                                                       32'($signed($urandom) >>> 2)});
         csr_write(mlm_pkg::CSR_WINDOW_LENGTH, 64'($urandom_range(1, 24)));
         repeat (50) random_frame(6);
         drain();
      end
   endtask

   task automatic test_random_stream();
      load_k_weighting();
      csr_write(mlm_pkg::CSR_LOUDNESS_FLOOR, -64'sd12000);
      csr_write(mlm_pkg::CSR_WINDOW_LENGTH, 64'($urandom_range(16, 200)));
      repeat (300) random_frame(7);
      drain();
      csr_write(mlm_pkg::CSR_WINDOW_LENGTH, 64'($urandom_range(2, 64)));
      repeat (200) random_frame(7);
      idle_on = 1'b0;
      repeat (150) random_frame(7);
      drain();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.left_sample = '0;
      req_chan.right_sample = '0;
      req_chan.two_channels = 1'b0;
      req_chan.block_end = 1'b0;
      req_chan.clear_peak = 1'b0;
      rsp_chan.ready = 1'b1;
      meter_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      idle_on = 1'b1;
      test_directed_extremes();
      test_window_lengths();
      test_floor_settings();
      test_random_coefs();
      test_random_stream();

      $display("covered %0d frames and %0d loudness words over coefficient, window and floor",
               frame_cnt, word_cnt);
      $display("settings, with idle and stall bursts on both channels");
      if (mismatch_cnt == 0 && loud_expect_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
